### src/nearest_first_request_board_top_defines.svh
// Assertion macros for the nearest-first request board.
// Included by the checker; depends on nothing else.
`ifndef NEAREST_FIRST_REQUEST_BOARD_TOP_DEFINES_SVH
`define NEAREST_FIRST_REQUEST_BOARD_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/nfrb_pkg.sv
// Shared types and constants of the nearest-first request board.
// No dependencies; imported by every module of the block but nfrb_ram.
`default_nettype none

package nfrb_pkg;

  localparam int unsigned LIMIT_BITS = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  // Register index of board_limit, taken from paddr bit 2.
  localparam logic REG_BOARD_LIMIT = 1'b0;

  localparam logic OP_POST  = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  typedef enum logic [1:0] {
    ST_POSTED  = 2'd0,
    ST_REFUSED = 2'd1,
    ST_SERVED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic post_probe;
    logic serve_read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic op_serve;
    logic cant_post;
    logic is_empty;
    logic free_hit;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### src/nfrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nfrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/nfrb_ctrl.sv
// Sequencing state machine of the request board.
// Depends on nfrb_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module nfrb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  output logic                s_ready_o,
  input  wire nfrb_pkg::stat_t stat_i,
  output nfrb_pkg::cmd_t      cmd_o
);
  import nfrb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE        = 6'b000001,
    S_CHECK       = 6'b000010,
    S_POST_SCAN   = 6'b000100,
    S_SERVE_SCAN  = 6'b001000,
    S_SERVE_DRAIN = 6'b010000,
    S_FINISH      = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    s_ready_o        = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
        if (s_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.op_serve) begin
          state_d = stat_i.cant_post ? S_FINISH : S_POST_SCAN;
        end else begin
          state_d = stat_i.is_empty ? S_FINISH : S_SERVE_SCAN;
        end
      end
      S_POST_SCAN: begin
        // A free slot always exists here, since the count is below the limit.
        cmd_o.post_probe = 1'b1;
        if (stat_i.free_hit) begin
          state_d = S_FINISH;
        end
      end
      S_SERVE_SCAN: begin
        cmd_o.serve_read = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_SERVE_DRAIN;
        end
      end
      S_SERVE_DRAIN: begin
        // The last read returns and is compared in this cycle.
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/nfrb_datapath.sv
// Slot storage, valid bits, nearest-distance search and result register.
// Depends on nfrb_pkg and nfrb_ram; commanded by nfrb_ctrl.
`default_nettype none

module nfrb_datapath #(
  parameter int unsigned BOARD_SLOTS    = 16,
  parameter int unsigned NUMBER_BITS    = 10,
  parameter int unsigned REQUESTER_BITS = 4,
  localparam int unsigned SLOT_BITS     = $clog2(BOARD_SLOTS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nfrb_pkg::cmd_t                cmd_i,
  output nfrb_pkg::stat_t                    stat_o,
  input  wire logic [nfrb_pkg::LIMIT_BITS-1:0] limit_i,
  input  wire logic                          in_op_i,
  input  wire logic [NUMBER_BITS-1:0]        in_number_i,
  input  wire logic [REQUESTER_BITS-1:0]     in_requester_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output nfrb_pkg::status_e                  out_status_o,
  output logic      [SLOT_BITS-1:0]          out_slot_o,
  output logic      [NUMBER_BITS-1:0]        out_number_o,
  output logic      [REQUESTER_BITS-1:0]     out_requester_o,
  output logic                               out_full_o
);
  import nfrb_pkg::*;

  localparam int unsigned CNT_BITS  = $clog2(BOARD_SLOTS + 1);
  localparam int unsigned CMP_BITS  = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;
  localparam int unsigned ENTRY_BITS = NUMBER_BITS + REQUESTER_BITS;

  // Captured request.
  logic                      op_q;
  logic [NUMBER_BITS-1:0]    num_q;
  logic [REQUESTER_BITS-1:0] req_q;

  // Board state.
  logic [BOARD_SLOTS-1:0]    valid_q;
  logic [CNT_BITS-1:0]       count_q;
  logic signed [NUMBER_BITS:0] last_q;

  // Scan and search.
  logic [SLOT_BITS-1:0]      cnt_q;
  logic                      p_vld_q;
  logic                      p_hit_q;
  logic [SLOT_BITS-1:0]      p_idx_q;
  logic                      best_found_q;
  logic [SLOT_BITS-1:0]      best_idx_q;
  logic [NUMBER_BITS:0]      best_dist_q;
  logic [NUMBER_BITS-1:0]    best_num_q;
  logic [REQUESTER_BITS-1:0] best_req_q;

  // Result register.
  logic                      out_valid_q;
  status_e                   out_status_q;
  logic [SLOT_BITS-1:0]      out_slot_q;
  logic [NUMBER_BITS-1:0]    out_number_q;
  logic [REQUESTER_BITS-1:0] out_requester_q;
  logic                      out_full_q;

  logic [ENTRY_BITS-1:0]     rd_data;
  logic [NUMBER_BITS-1:0]    rd_num;
  logic [REQUESTER_BITS-1:0] rd_req;
  logic signed [NUMBER_BITS+1:0] diff;
  logic signed [NUMBER_BITS+1:0] mag;
  logic [NUMBER_BITS:0]      cand_dist;
  logic                      take;
  logic [CMP_BITS-1:0]       limit_ext;
  logic [CMP_BITS-1:0]       eff_lim;
  logic                      cant_post;
  logic                      do_post;
  logic                      do_serve;
  logic [CNT_BITS-1:0]       count_n;
  status_e                   status_n;

  assign limit_ext = CMP_BITS'(limit_i);
  assign eff_lim   = (limit_ext > CMP_BITS'(BOARD_SLOTS)) ? CMP_BITS'(BOARD_SLOTS) : limit_ext;
  assign cant_post = CMP_BITS'(count_q) >= eff_lim;

  nfrb_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (BOARD_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_post),
    .waddr_i (cnt_q),
    .wdata_i ({req_q, num_q}),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  assign rd_num = rd_data[NUMBER_BITS-1:0];
  assign rd_req = rd_data[ENTRY_BITS-1:NUMBER_BITS];

  assign diff      = $signed({last_q[NUMBER_BITS], last_q}) - $signed({2'b00, rd_num});
  assign mag       = diff[NUMBER_BITS+1] ? -diff : diff;
  assign cand_dist = mag[NUMBER_BITS:0];
  // Ties go to the later slot, which is the higher index.
  assign take = p_vld_q && p_hit_q && (!best_found_q || (cand_dist <= best_dist_q));

  assign do_post  = cmd_i.commit && (op_q == OP_POST) && !cant_post;
  assign do_serve = cmd_i.commit && (op_q == OP_SERVE) && best_found_q;

  always_comb begin
    count_n = count_q;
    if (op_q == OP_POST) begin
      status_n = cant_post ? ST_REFUSED : ST_POSTED;
      if (!cant_post) begin
        count_n = count_q + CNT_BITS'(1);
      end
    end else begin
      status_n = best_found_q ? ST_SERVED : ST_EMPTY;
      if (best_found_q) begin
        count_n = count_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      num_q <= in_number_i;
      req_q <= in_requester_i;
    end
    p_idx_q <= cnt_q;
    p_hit_q <= valid_q[cnt_q];
    if (take) begin
      best_idx_q  <= p_idx_q;
      best_dist_q <= cand_dist;
      best_num_q  <= rd_num;
      best_req_q  <= rd_req;
    end
    if (cmd_i.commit) begin
      out_status_q    <= status_n;
      out_slot_q      <= (op_q == OP_POST) ? (cant_post ? '0 : cnt_q)
                                           : (best_found_q ? best_idx_q : '0);
      out_number_q    <= do_serve ? best_num_q : '0;
      out_requester_q <= do_serve ? best_req_q : '0;
      out_full_q      <= CMP_BITS'(count_n) >= eff_lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      last_q       <= '1;
      cnt_q        <= '0;
      p_vld_q      <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.serve_read;
      if (cmd_i.load) begin
        cnt_q        <= '0;
        best_found_q <= 1'b0;
      end else begin
        if (cmd_i.serve_read || (cmd_i.post_probe && valid_q[cnt_q])) begin
          cnt_q <= cnt_q + SLOT_BITS'(1);
        end
        if (take) begin
          best_found_q <= 1'b1;
        end
      end
      if (do_post) begin
        valid_q[cnt_q] <= 1'b1;
      end
      if (do_serve) begin
        valid_q[best_idx_q] <= 1'b0;
        last_q              <= $signed({1'b0, best_num_q});
      end
      if (cmd_i.commit) begin
        count_q     <= count_n;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.op_serve  = (op_q == OP_SERVE);
  assign stat_o.cant_post = cant_post;
  assign stat_o.is_empty  = (count_q == '0);
  assign stat_o.free_hit  = !valid_q[cnt_q];
  assign stat_o.scan_last = (cnt_q == SLOT_BITS'(BOARD_SLOTS - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_slot_o      = out_slot_q;
  assign out_number_o    = out_number_q;
  assign out_requester_o = out_requester_q;
  assign out_full_o      = out_full_q;

endmodule

`default_nettype wire

### src/nearest_first_request_board_top.sv
// Nearest-first request board: one request at a time, post or serve.
// Post: scans the valid bits from slot 0, past occupied slots, to the first free slot;
// a refused post skips the scan. Serve: reads every slot of the slot RAM, one entry per
// cycle, and keeps the nearest; serve on an empty board skips the scan.
// Reset (rst_ni, asynchronous, active low) empties the board, sets the last served
// number to -1 and board_limit to 16; the slot RAM needs no clearing pass.
`default_nettype none

module nearest_first_request_board_top #(
  parameter int unsigned BOARD_SLOTS    = 16,
  parameter int unsigned NUMBER_BITS    = 10,
  parameter int unsigned REQUESTER_BITS = 4,
  localparam int unsigned SLOT_BITS     = $clog2(BOARD_SLOTS),
  localparam int unsigned IN_BITS       = NUMBER_BITS + REQUESTER_BITS,
  localparam int unsigned IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS      = SLOT_BITS + NUMBER_BITS + REQUESTER_BITS + 1,
  localparam int unsigned OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // request_number, requester_id
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // operation
  input  wire logic [7:0]                s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // slot_index, served_number, served_requester, board_full
  output logic      [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // status
  output logic      [7:0]                m_axis_tuser,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  import nfrb_pkg::*;

  logic [LIMIT_BITS-1:0]     limit_q;
  cmd_t                      cmd;
  stat_t                     stat;
  status_e                   out_status;
  logic [SLOT_BITS-1:0]      out_slot;
  logic [NUMBER_BITS-1:0]    out_number;
  logic [REQUESTER_BITS-1:0] out_requester;
  logic                      out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BOARD_LIMIT)) begin
      limit_q <= pwdata[LIMIT_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BOARD_LIMIT) ? 32'(limit_q) : '0;

  nfrb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  nfrb_datapath #(
    .BOARD_SLOTS    (BOARD_SLOTS),
    .NUMBER_BITS    (NUMBER_BITS),
    .REQUESTER_BITS (REQUESTER_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .limit_i         (limit_q),
    .in_op_i         (s_axis_tuser[0]),
    .in_number_i     (s_axis_tdata[NUMBER_BITS-1:0]),
    .in_requester_i  (s_axis_tdata[IN_BITS-1:NUMBER_BITS]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_status_o    (out_status),
    .out_slot_o      (out_slot),
    .out_number_o    (out_number),
    .out_requester_o (out_requester),
    .out_full_o      (out_full)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'({out_full, out_requester, out_number, out_slot});
  assign m_axis_tuser = 8'(out_status);

endmodule

`default_nettype wire

### src/nfrb_checker.sv
// Port-level checks of the nearest-first request board, bound to the top level.
// Depends on nfrb_pkg and the assertion macros header.
`default_nettype none
`include "nearest_first_request_board_top_defines.svh"

module nfrb_checker #(
  parameter int unsigned BOARD_SLOTS    = 16,
  parameter int unsigned NUMBER_BITS    = 10,
  parameter int unsigned REQUESTER_BITS = 4,
  localparam int unsigned SLOT_BITS     = $clog2(BOARD_SLOTS),
  localparam int unsigned FIELD_BITS    = SLOT_BITS + NUMBER_BITS + REQUESTER_BITS,
  localparam int unsigned OUT_BITS      = FIELD_BITS + 1,
  localparam int unsigned OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input wire logic [7:0]                m_axis_tuser
);
  import nfrb_pkg::*;

  logic [1:0] status;
  assign status = m_axis_tuser[1:0];

  `NFRB_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `NFRB_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in work")

  `NFRB_ASSERT_IMP(a_no_entry_zero, clk_i, rst_ni, m_axis_tvalid && (status == ST_REFUSED || status == ST_EMPTY), m_axis_tdata[FIELD_BITS-1:0] == '0, "refused or empty result carries data")

  `NFRB_ASSERT_IMP(a_post_no_served, clk_i, rst_ni, m_axis_tvalid && (status == ST_POSTED), m_axis_tdata[FIELD_BITS-1:SLOT_BITS] == '0, "posted result carries served fields")

endmodule

bind nearest_first_request_board_top nfrb_checker #(
  .BOARD_SLOTS    (BOARD_SLOTS),
  .NUMBER_BITS    (NUMBER_BITS),
  .REQUESTER_BITS (REQUESTER_BITS)
) u_nfrb_checker (.*);

`default_nettype wire
